@@ rtl/d2pc_pkg.sv @@
`default_nettype none
package d2pc_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH    = 4;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [2:0] REG_INV_FOCAL_X  = 3'd0;
    localparam logic [2:0] REG_INV_FOCAL_Y  = 3'd1;
    localparam logic [2:0] REG_CENTER_X     = 3'd2;
    localparam logic [2:0] REG_CENTER_Y     = 3'd3;
    localparam logic [2:0] REG_DEPTH_FACTOR = 3'd4;
    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd5;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd6;
    localparam logic [2:0] REG_DOWNSAMPLE   = 3'd7;

    localparam logic [31:0] INV_FOCAL_X_RST  = 32'd8180952;
    localparam logic [31:0] INV_FOCAL_Y_RST  = 32'd8180952;
    localparam logic [15:0] CENTER_X_RST     = 16'd5112;
    localparam logic [15:0] CENTER_Y_RST     = 16'd3832;
    localparam logic [31:0] DEPTH_FACTOR_RST = 32'd4294967;
    localparam logic [12:0] IMAGE_WIDTH_RST  = 13'd640;
    localparam logic [12:0] IMAGE_HEIGHT_RST = 13'd480;
    localparam logic [4:0]  DOWNSAMPLE_RST   = 5'd1;

    localparam logic [4:0]  DOWNSAMPLE_MAX   = 5'd16;

    typedef struct packed {
        logic [31:0] inv_focal_x;
        logic [31:0] inv_focal_y;
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [31:0] depth_factor;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic [4:0]  downsample;
    } d2pc_cfg_t;

endpackage
`default_nettype wire

@@ rtl/d2pc_pixel_if.sv @@
`default_nettype none
interface d2pc_pixel_if;
    logic        valid;
    logic        ready;
    logic [15:0] depth;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;

    modport source (output valid, output depth, output blue, output green, output red,
                    input ready);
    modport sink (input valid, input depth, input blue, input green, input red,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/d2pc_point_if.sv @@
`default_nettype none
interface d2pc_point_if;
    logic               valid;
    logic               ready;
    logic [23:0]        point_index;
    logic               point_valid;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [23:0]        packed_color;

    modport source (output valid, output point_index, output point_valid, output pos_x,
                    output pos_y, output pos_z, output packed_color, input ready);
    modport sink (input valid, input point_index, input point_valid, input pos_x,
                  input pos_y, input pos_z, input packed_color, output ready);
endinterface
`default_nettype wire

@@ rtl/d2pc_front.sv @@
`default_nettype none
module d2pc_front
    import d2pc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int ENTRY_W    = 64 + 2 * COORD_BITS
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire d2pc_cfg_t          cfg,
    d2pc_pixel_if.sink              pix,
    input  wire logic               q_full,
    output logic                    q_push,
    output logic [ENTRY_W-1:0]      q_data
);

    localparam int CMP_W = (COORD_BITS + 2 > 14) ? COORD_BITS + 2 : 14;
    localparam logic [CMP_W-1:0] LIMIT = CMP_W'(1) << COORD_BITS;

    logic [COORD_BITS-1:0] column_count_reg, column_count_next;
    logic [COORD_BITS-1:0] row_count_reg, row_count_next;
    logic [3:0]            column_phase_reg, column_phase_next;
    logic [3:0]            row_phase_reg, row_phase_next;
    logic [23:0]           point_counter_reg, point_counter_next;

    logic [CMP_W-1:0] width_raw, height_raw, width_eff, height_eff;
    logic [CMP_W-1:0] column_inc, row_inc;
    logic [4:0]       ds_eff, column_phase_inc, row_phase_inc;
    logic             accept, keep;

    assign pix.ready = !q_full;
    assign accept    = pix.valid && !q_full;
    assign keep      = (column_phase_reg == 4'd0) && (row_phase_reg == 4'd0);
    assign q_push    = accept && keep;
    assign q_data    = {point_counter_reg, pix.red, pix.green, pix.blue, pix.depth,
                        row_count_reg, column_count_reg};

    always_comb
    begin
        width_raw  = CMP_W'(cfg.image_width);
        height_raw = CMP_W'(cfg.image_height);
        width_eff  = (width_raw == '0 || width_raw > LIMIT) ? LIMIT : width_raw;
        height_eff = (height_raw == '0 || height_raw > LIMIT) ? LIMIT : height_raw;
        if (cfg.downsample == 5'd0)
        begin
            ds_eff = 5'd1;
        end
        else if (cfg.downsample > DOWNSAMPLE_MAX)
        begin
            ds_eff = DOWNSAMPLE_MAX;
        end
        else
        begin
            ds_eff = cfg.downsample;
        end
        column_inc       = CMP_W'(column_count_reg) + CMP_W'(1);
        row_inc          = CMP_W'(row_count_reg) + CMP_W'(1);
        column_phase_inc = {1'b0, column_phase_reg} + 5'd1;
        row_phase_inc    = {1'b0, row_phase_reg} + 5'd1;

        column_count_next  = column_count_reg;
        row_count_next     = row_count_reg;
        column_phase_next  = column_phase_reg;
        row_phase_next     = row_phase_reg;
        point_counter_next = keep ? point_counter_reg + 24'd1 : point_counter_reg;

        if (column_inc >= width_eff)
        begin
            column_count_next = '0;
            column_phase_next = 4'd0;
            if (row_inc >= height_eff)
            begin
                row_count_next     = '0;
                row_phase_next     = 4'd0;
                point_counter_next = 24'd0;
            end
            else
            begin
                row_count_next = row_inc[COORD_BITS-1:0];
                row_phase_next = (row_phase_inc >= ds_eff) ? 4'd0 : row_phase_inc[3:0];
            end
        end
        else
        begin
            column_count_next = column_inc[COORD_BITS-1:0];
            column_phase_next = (column_phase_inc >= ds_eff) ? 4'd0 : column_phase_inc[3:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg  <= '0;
            row_count_reg     <= '0;
            column_phase_reg  <= 4'd0;
            row_phase_reg     <= 4'd0;
            point_counter_reg <= 24'd0;
        end
        else if (accept)
        begin
            column_count_reg  <= column_count_next;
            row_count_reg     <= row_count_next;
            column_phase_reg  <= column_phase_next;
            row_phase_reg     <= row_phase_next;
            point_counter_reg <= point_counter_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/d2pc_queue.sv @@
`default_nettype none
module d2pc_queue
    import d2pc_pkg::*;
#(
    parameter int DATA_W = 88,
    parameter int DEPTH  = QUEUE_DEPTH
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   full,
    input  wire logic              pop,
    output logic                   not_empty,
    output logic [DATA_W-1:0]      pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/d2pc_back.sv @@
`default_nettype none
module d2pc_back
    import d2pc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int ENTRY_W    = 64 + 2 * COORD_BITS
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire d2pc_cfg_t          cfg,
    input  wire logic               q_valid,
    input  wire logic [ENTRY_W-1:0] q_data,
    output logic                    q_pop,
    d2pc_point_if.source            pts
);

    localparam int OFF_W  = (COORD_BITS + 4 > 16) ? COORD_BITS + 4 : 16;
    localparam int PART_W = 20 + OFF_W;
    localparam int ZS     = 32 - FRAC_BITS;
    localparam int XS     = 28 - FRAC_BITS;
    localparam logic [63:0] Z_HALF = 64'd1 << (ZS - 1);
    localparam logic [63:0] X_HALF = 64'd1 << (XS - 1);
    localparam logic [63:0] POS_MAX = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] NEG_MAX = 64'h0000_0000_8000_0000;

    // Six stages behind the queue plus the output register; all move together.
    logic [6:1] stage_valid_reg;
    logic       out_valid_reg;
    logic       adv;

    logic [COORD_BITS-1:0] in_col, in_row;
    logic [15:0]           in_depth;
    logic [23:0]           in_color, in_index;
    logic [OFF_W-1:0]      pos_col, pos_row, cen_x, cen_y, off_x, off_y;
    logic                  neg_x, neg_y;

    // Stage payload (no reset).
    logic [47:0]        full_reg;
    logic [OFF_W-1:0]   off_x_reg [1:4];
    logic [OFF_W-1:0]   off_y_reg [1:4];
    logic               neg_x_reg [1:6];
    logic               neg_y_reg [1:6];
    logic               nz_reg    [1:6];
    logic [23:0]        color_reg [1:6];
    logic [23:0]        index_reg [1:6];
    logic [31:0]        dist_reg;
    logic [31:0]        pz_reg    [2:6];
    logic [63:0]        prod_x_reg, prod_y_reg;
    logic [39:0]        q_x_reg, q_y_reg;
    logic [PART_W-1:0]  lo_x_reg, hi_x_reg, lo_y_reg, hi_y_reg;
    logic [63:0]        m_x_reg, m_y_reg;

    logic [23:0]        out_index_reg, out_color_reg;
    logic               out_pvalid_reg;
    logic [31:0]        out_x_reg, out_y_reg, out_z_reg;

    logic [63:0] full_ext, dist_sum, z_sum, z_mag, qx_sum, qy_sum, x_mag, y_mag;
    logic [31:0] pz_sat, px_sat, py_sat;

    function automatic logic [31:0] sat_signed(input logic [63:0] mag, input logic neg);
        logic [31:0] res;
        if (neg)
        begin
            res = (mag >= NEG_MAX) ? 32'h8000_0000 : 32'd0 - mag[31:0];
        end
        else
        begin
            res = (mag > POS_MAX) ? 32'h7FFF_FFFF : mag[31:0];
        end
        return res;
    endfunction

    assign adv   = !out_valid_reg || pts.ready;
    assign q_pop = adv && q_valid;

    assign {in_index, in_color, in_depth, in_row, in_col} = q_data;

    always_comb
    begin
        pos_col = OFF_W'({in_col, 4'b0000});
        pos_row = OFF_W'({in_row, 4'b0000});
        cen_x   = OFF_W'(cfg.center_x);
        cen_y   = OFF_W'(cfg.center_y);
        neg_x   = cen_x > pos_col;
        neg_y   = cen_y > pos_row;
        off_x   = neg_x ? cen_x - pos_col : pos_col - cen_x;
        off_y   = neg_y ? cen_y - pos_row : pos_row - cen_y;

        full_ext = {16'd0, full_reg};
        dist_sum = full_ext + 64'h0000_0000_0000_8000;
        z_sum    = full_ext + Z_HALF;
        z_mag    = z_sum >> ZS;
        pz_sat   = sat_signed(z_mag, 1'b0);

        qx_sum = prod_x_reg + 64'h0000_0000_0080_0000;
        qy_sum = prod_y_reg + 64'h0000_0000_0080_0000;

        x_mag  = (m_x_reg + X_HALF) >> XS;
        y_mag  = (m_y_reg + X_HALF) >> XS;
        px_sat = sat_signed(x_mag, neg_x_reg[6]);
        py_sat = sat_signed(y_mag, neg_y_reg[6]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // Stage 1: depth times depth factor, pixel offsets from the principal point.
            full_reg     <= in_depth * cfg.depth_factor;
            off_x_reg[1] <= off_x;
            off_y_reg[1] <= off_y;
            neg_x_reg[1] <= neg_x;
            neg_y_reg[1] <= neg_y;
            nz_reg[1]    <= in_depth != 16'd0;
            color_reg[1] <= in_color;
            index_reg[1] <= in_index;

            // Stage 2: distance with 16 fraction bits and the saturated z.
            dist_reg  <= dist_sum[47:16];
            pz_reg[2] <= pz_sat;

            // Stage 3: distance times inverse focal length.
            prod_x_reg <= dist_reg * cfg.inv_focal_x;
            prod_y_reg <= dist_reg * cfg.inv_focal_y;

            // Stage 4: rounded to 24 fraction bits.
            q_x_reg <= qx_sum[63:24];
            q_y_reg <= qy_sum[63:24];

            // Stage 5: the 40-bit scale times the offset in two 20-bit halves.
            lo_x_reg <= q_x_reg[19:0] * off_x_reg[4];
            hi_x_reg <= q_x_reg[39:20] * off_x_reg[4];
            lo_y_reg <= q_y_reg[19:0] * off_y_reg[4];
            hi_y_reg <= q_y_reg[39:20] * off_y_reg[4];

            // Stage 6: halves recombined.
            m_x_reg <= (64'(hi_x_reg) << 20) + 64'(lo_x_reg);
            m_y_reg <= (64'(hi_y_reg) << 20) + 64'(lo_y_reg);

            for (int s = 2; s <= 4; s++)
            begin
                off_x_reg[s] <= off_x_reg[s-1];
                off_y_reg[s] <= off_y_reg[s-1];
            end
            for (int s = 2; s <= 6; s++)
            begin
                neg_x_reg[s] <= neg_x_reg[s-1];
                neg_y_reg[s] <= neg_y_reg[s-1];
                nz_reg[s]    <= nz_reg[s-1];
                color_reg[s] <= color_reg[s-1];
                index_reg[s] <= index_reg[s-1];
            end
            for (int s = 3; s <= 6; s++)
            begin
                pz_reg[s] <= pz_reg[s-1];
            end

            // Output: rounding to the output fraction and saturation.
            out_index_reg  <= index_reg[6];
            out_color_reg  <= color_reg[6];
            out_pvalid_reg <= nz_reg[6];
            out_x_reg      <= px_sat;
            out_y_reg      <= py_sat;
            out_z_reg      <= pz_reg[6];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else if (adv)
        begin
            stage_valid_reg <= {stage_valid_reg[5:1], q_valid};
            out_valid_reg   <= stage_valid_reg[6];
        end
    end

    assign pts.valid        = out_valid_reg;
    assign pts.point_index  = out_index_reg;
    assign pts.point_valid  = out_pvalid_reg;
    assign pts.pos_x        = out_x_reg;
    assign pts.pos_y        = out_y_reg;
    assign pts.pos_z        = out_z_reg;
    assign pts.packed_color = out_color_reg;

endmodule
`default_nettype wire

@@ rtl/depth_to_point_cloud.sv @@
// A kept pixel is written to the queue, then passes through the multiply pipeline and its output register.
// Throughput: one pixel per cycle; a stalled output holds the multiply pipeline, and the
// four-entry queue between the pixel counters and that pipeline then fills and drops ready.
// Reset (rst_n, asynchronous, active low) loads the register defaults, clears the column,
// row, phase and point counters and empties the queue and the pipeline.
`default_nettype none
module depth_to_point_cloud
    import d2pc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    d2pc_pixel_if.sink                 pix,
    d2pc_point_if.source               pts
);

    localparam int ENTRY_W = 64 + 2 * COORD_BITS;

    d2pc_cfg_t          cfg_reg;
    logic               cfg_write;
    logic [2:0]         reg_index;
    logic               q_full, q_push, q_valid, q_pop;
    logic [ENTRY_W-1:0] q_wdata, q_rdata;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inv_focal_x  <= INV_FOCAL_X_RST;
            cfg_reg.inv_focal_y  <= INV_FOCAL_Y_RST;
            cfg_reg.center_x     <= CENTER_X_RST;
            cfg_reg.center_y     <= CENTER_Y_RST;
            cfg_reg.depth_factor <= DEPTH_FACTOR_RST;
            cfg_reg.image_width  <= IMAGE_WIDTH_RST;
            cfg_reg.image_height <= IMAGE_HEIGHT_RST;
            cfg_reg.downsample   <= DOWNSAMPLE_RST;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_INV_FOCAL_X:  cfg_reg.inv_focal_x  <= pwdata;
                REG_INV_FOCAL_Y:  cfg_reg.inv_focal_y  <= pwdata;
                REG_CENTER_X:     cfg_reg.center_x     <= pwdata[15:0];
                REG_CENTER_Y:     cfg_reg.center_y     <= pwdata[15:0];
                REG_DEPTH_FACTOR: cfg_reg.depth_factor <= pwdata;
                REG_IMAGE_WIDTH:  cfg_reg.image_width  <= pwdata[12:0];
                REG_IMAGE_HEIGHT: cfg_reg.image_height <= pwdata[12:0];
                REG_DOWNSAMPLE:   cfg_reg.downsample   <= pwdata[4:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_INV_FOCAL_X:  prdata = cfg_reg.inv_focal_x;
            REG_INV_FOCAL_Y:  prdata = cfg_reg.inv_focal_y;
            REG_CENTER_X:     prdata = APB_DATA_W'(cfg_reg.center_x);
            REG_CENTER_Y:     prdata = APB_DATA_W'(cfg_reg.center_y);
            REG_DEPTH_FACTOR: prdata = cfg_reg.depth_factor;
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(cfg_reg.image_width);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(cfg_reg.image_height);
            REG_DOWNSAMPLE:   prdata = APB_DATA_W'(cfg_reg.downsample);
            default:          prdata = '0;
        endcase
    end

    d2pc_front #(
        .COORD_BITS (COORD_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .pix    (pix),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_wdata)
    );

    d2pc_queue #(
        .DATA_W (ENTRY_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_rdata)
    );

    d2pc_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .pts     (pts)
    );

endmodule
`default_nettype wire

@@ rtl/d2pc_checker.sv @@
`default_nettype none
module d2pc_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        pready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        point_valid,
    input wire logic [31:0] pos_x,
    input wire logic [31:0] pos_y,
    input wire logic [31:0] pos_z,
    input wire logic [23:0] point_index
);

    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("point request withdrawn while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(point_index) && $stable(pos_x)
                                    && $stable(pos_y) && $stable(pos_z))
        else $error("point payload changed while stalled");

    a_missing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !point_valid |-> pos_x == 32'd0 && pos_y == 32'd0 && pos_z == 32'd0)
        else $error("missing depth gave nonzero coordinates");

    a_z_positive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && point_valid |-> !pos_z[31])
        else $error("negative z on a measured point");

endmodule

bind depth_to_point_cloud d2pc_checker u_d2pc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pready      (pready),
    .out_valid   (pts.valid),
    .out_ready   (pts.ready),
    .point_valid (pts.point_valid),
    .pos_x       (pts.pos_x),
    .pos_y       (pts.pos_y),
    .pos_z       (pts.pos_z),
    .point_index (pts.point_index)
);
`default_nettype wire
